// ===== hw/rtl/emrg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emrg_pkg
// Shared constants, types and command/status structs of the maze row
// generator.
// ----------------------------------------------------------------------------
package emrg_pkg;

  localparam int COLUMNS_DEF = 16;
  localparam int LABEL_W     = 20;
  localparam int ROW_W       = 16;
  localparam int CIU_W       = 5;
  localparam int WORD_W      = 31;
  localparam int DIV_STEPS   = WORD_W;
  localparam int DCNT_W      = 5;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  // Register indexes (byte address is four times the index).
  localparam logic [1:0] REG_ROW_COUNT      = 2'd0;
  localparam logic [1:0] REG_COLS_IN_USE    = 2'd1;
  localparam logic [1:0] REG_OPEN_THRESHOLD = 2'd2;

  // Register reset values.
  localparam logic [ROW_W-1:0]  ROW_COUNT_RST = 16'd1;
  localparam logic [CIU_W-1:0]  COLS_RST      = 5'd16;
  localparam logic [WORD_W-1:0] THRESH_RST    = 31'h4000_0000;

  // Algorithm phase, kept across words.
  typedef enum logic [2:0] {
    PH_START,
    PH_ROW,
    PH_VWALK,
    PH_SETFIRST,
    PH_SETNEXT,
    PH_FAILSAFE,
    PH_MEMBER
  } phase_t;

  // Handling of the current word.
  typedef enum logic [2:0] {
    MD_IDLE,
    MD_RUN,
    MD_DIV,
    MD_OUT0,
    MD_OUT1
  } mode_t;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_FILL,
    OP_ROW_INIT,
    OP_VW_SAME,
    OP_VW_DRAW,
    OP_PICK_CLR,
    OP_PICK_COL,
    OP_PICK_TAKE,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_SKIP,
    OP_MEMBER_DRAW,
    OP_MEMBER_END,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   load;
    logic   slot;
    logic   first;
    logic   last;
  } dp_cmd_t;

  typedef struct packed {
    logic walk_lt_w;
    logic pair_end;
    logic pair_same;
    logic found;
    logic at_cur;
    logic div_last;
    logic last_row;
  } dp_stat_t;

endpackage

// ===== hw/rtl/emrg_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emrg_dp
// Datapath: column labels, wall vectors, set search, remainder unit and
// the two-entry result buffer.
// ----------------------------------------------------------------------------
module emrg_dp
  import emrg_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic [WORD_W-1:0]   in_word,
  input  logic [ROW_W-1:0]    row_count,
  input  logic [CIU_W-1:0]    cols_in_use,
  input  logic [WORD_W-1:0]   open_threshold,
  input  logic                out_slot,
  output logic [ROW_W-1:0]    row_index,
  output logic [COLUMNS:0]    vertical_walls,
  output logic [COLUMNS-1:0]  horizontal_walls,
  output logic                final_row
);

  localparam int CW = $clog2(COLUMNS + 1);
  localparam int IW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  logic [LABEL_W-1:0] labels_r [COLUMNS];
  logic [LABEL_W-1:0] labels_nxt [COLUMNS];
  logic [COLUMNS-1:0] valid_r, valid_nxt;
  logic [LABEL_W-1:0] fresh_r, fresh_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [CW-1:0]      walk_r, walk_nxt;
  logic [LABEL_W-1:0] cur_r, cur_nxt;
  logic [LABEL_W-1:0] best_r, best_nxt;
  logic               found_r, found_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      size_r, size_nxt;
  logic [CW-1:0]      cd_r, cd_nxt;
  logic [IW-1:0]      fs_col_r, fs_col_nxt;
  logic               opened_r, opened_nxt;
  logic [COLUMNS:0]   vert_r, vert_nxt;
  logic [COLUMNS-1:0] hor_r, hor_nxt;
  logic [WORD_W-1:0]  word_r, word_nxt;
  logic [CW-1:0]      rem_r, rem_nxt;
  logic [DCNT_W-1:0]  dcnt_r, dcnt_nxt;
  logic [ROW_W-1:0]   res_row_r [2];
  logic [ROW_W-1:0]   res_row_nxt [2];
  logic [COLUMNS:0]   res_vert_r [2];
  logic [COLUMNS:0]   res_vert_nxt [2];
  logic [COLUMNS-1:0] res_hor_r [2];
  logic [COLUMNS-1:0] res_hor_nxt [2];
  logic [1:0]         res_last_r, res_last_nxt;

  logic [5:0]         cu;
  logic [CW-1:0]      w;
  logic [CW-1:0]      walk_p1;
  logic [IW-1:0]      wi, wi1;
  logic [LABEL_W-1:0] lab_a, lab_b;
  logic [ROW_W-1:0]   rc;
  logic               hit;
  logic [COLUMNS-1:0] mask_w;
  logic [CW:0]        trial;
  logic [CW-1:0]      rem_new;

  // Effective width, clipped to one through COLUMNS.
  assign cu = {1'b0, cols_in_use};
  always_comb begin
    if (cu == 6'd0) begin
      w = CW'(1);
    end else if (cu > 6'(COLUMNS)) begin
      w = CW'(COLUMNS);
    end else begin
      w = cu[CW-1:0];
    end
  end

  assign walk_p1 = walk_r + CW'(1);
  assign wi      = walk_r[IW-1:0];
  assign wi1     = walk_p1[IW-1:0];
  assign lab_a   = labels_r[wi];
  assign lab_b   = labels_r[wi1];
  assign rc      = (row_count == '0) ? ROW_W'(1) : row_count;
  assign hit     = word_r < open_threshold;

  always_comb begin
    for (int k = 0; k < COLUMNS; k++) begin
      mask_w[k] = CW'(k) < w;
    end
  end

  // One restoring remainder step per cycle.
  assign trial   = {rem_r, word_r[WORD_W-1]};
  assign rem_new = (trial >= {1'b0, size_r}) ? CW'(trial - {1'b0, size_r}) : trial[CW-1:0];

  assign stat.walk_lt_w = walk_r < w;
  assign stat.pair_end  = ({1'b0, walk_r} + (CW+1)'(1)) >= {1'b0, w};
  assign stat.pair_same = lab_a == lab_b;
  assign stat.found     = found_r;
  assign stat.at_cur    = lab_a == cur_r;
  assign stat.div_last  = dcnt_r == DCNT_W'(DIV_STEPS - 1);
  assign stat.last_row  = ({1'b0, row_r} + (ROW_W+1)'(1)) >= {1'b0, rc};

  // Operation decode.
  always_comb begin
    labels_nxt   = labels_r;
    valid_nxt    = valid_r;
    fresh_nxt    = fresh_r;
    row_nxt      = row_r;
    walk_nxt     = walk_r;
    cur_nxt      = cur_r;
    best_nxt     = best_r;
    found_nxt    = found_r;
    cnt_nxt      = cnt_r;
    size_nxt     = size_r;
    cd_nxt       = cd_r;
    fs_col_nxt   = fs_col_r;
    opened_nxt   = opened_r;
    vert_nxt     = vert_r;
    hor_nxt      = hor_r;
    word_nxt     = word_r;
    rem_nxt      = rem_r;
    dcnt_nxt     = dcnt_r;
    res_row_nxt  = res_row_r;
    res_vert_nxt = res_vert_r;
    res_hor_nxt  = res_hor_r;
    res_last_nxt = res_last_r;
    if (cmd.load) begin
      word_nxt = in_word;
    end
    unique case (cmd.op)
      OP_NONE: begin
      end
      OP_START: begin
        valid_nxt = '0;
        fresh_nxt = '0;
        row_nxt   = '0;
        walk_nxt  = '0;
      end
      OP_FILL: begin
        if (!valid_r[wi]) begin
          labels_nxt[wi] = fresh_r;
          valid_nxt[wi]  = 1'b1;
          fresh_nxt      = fresh_r + LABEL_W'(1);
        end
        walk_nxt = walk_p1;
      end
      OP_ROW_INIT: begin
        vert_nxt    = '0;
        vert_nxt[0] = 1'b1;
        vert_nxt[w] = 1'b1;
        hor_nxt     = '0;
        walk_nxt    = '0;
      end
      OP_VW_SAME: begin
        vert_nxt[walk_p1] = 1'b1;
        walk_nxt          = walk_p1;
      end
      OP_VW_DRAW: begin
        // Wall on a hit in a normal row, else merge the right set in.
        if (!stat.last_row && hit) begin
          vert_nxt[walk_p1] = 1'b1;
        end else begin
          for (int k = 0; k < COLUMNS; k++) begin
            if (mask_w[k] && labels_r[k] == lab_b) begin
              labels_nxt[k] = lab_a;
            end
          end
        end
        walk_nxt = walk_p1;
      end
      OP_PICK_CLR: begin
        walk_nxt  = '0;
        found_nxt = 1'b0;
      end
      OP_PICK_COL: begin
        // Running minimum above the current label (any label in the first search), with its count.
        if (cmd.first || lab_a > cur_r) begin
          if (!found_r || lab_a < best_r) begin
            best_nxt  = lab_a;
            cnt_nxt   = CW'(1);
            found_nxt = 1'b1;
          end else if (lab_a == best_r) begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
        walk_nxt = walk_p1;
      end
      OP_PICK_TAKE: begin
        cur_nxt  = best_r;
        size_nxt = cnt_r;
      end
      OP_DIV_INIT: begin
        rem_nxt  = '0;
        dcnt_nxt = '0;
      end
      OP_DIV_STEP: begin
        rem_nxt  = rem_new;
        word_nxt = word_r << 1;
        dcnt_nxt = dcnt_r + DCNT_W'(1);
        if (stat.div_last) begin
          cd_nxt     = (size_r == '0) ? '0 : rem_new;
          fs_col_nxt = '0;
          opened_nxt = 1'b0;
          walk_nxt   = '0;
        end
      end
      OP_SKIP: begin
        walk_nxt = walk_p1;
      end
      OP_MEMBER_DRAW: begin
        if (cd_r == '0) begin
          fs_col_nxt = wi;
        end
        cd_nxt = cd_r - CW'(1);
        if (hit) begin
          opened_nxt = 1'b1;
        end else begin
          hor_nxt[wi] = 1'b1;
        end
        walk_nxt = walk_p1;
      end
      OP_MEMBER_END: begin
        // Fail-safe: reopen one member if the whole set was walled.
        if (!opened_r) begin
          hor_nxt[fs_col_r] = 1'b0;
        end
        walk_nxt  = '0;
        found_nxt = 1'b0;
      end
      OP_EMIT: begin
        res_row_nxt[cmd.slot]  = row_r;
        res_vert_nxt[cmd.slot] = vert_r;
        res_hor_nxt[cmd.slot]  = cmd.last ? mask_w : hor_r;
        res_last_nxt[cmd.slot] = cmd.last;
        if (!cmd.last) begin
          valid_nxt = valid_r & ~(hor_r & mask_w);
        end
        row_nxt  = row_r + ROW_W'(1);
        walk_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // State registers with a defined reset value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      fresh_r  <= '0;
      row_r    <= '0;
      walk_r   <= '0;
      cur_r    <= '0;
      found_r  <= 1'b0;
      size_r   <= '0;
      cd_r     <= '0;
      fs_col_r <= '0;
      opened_r <= 1'b0;
      vert_r   <= '0;
      hor_r    <= '0;
      dcnt_r   <= '0;
    end else begin
      valid_r  <= valid_nxt;
      fresh_r  <= fresh_nxt;
      row_r    <= row_nxt;
      walk_r   <= walk_nxt;
      cur_r    <= cur_nxt;
      found_r  <= found_nxt;
      size_r   <= size_nxt;
      cd_r     <= cd_nxt;
      fs_col_r <= fs_col_nxt;
      opened_r <= opened_nxt;
      vert_r   <= vert_nxt;
      hor_r    <= hor_nxt;
      dcnt_r   <= dcnt_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    labels_r   <= labels_nxt;
    best_r     <= best_nxt;
    cnt_r      <= cnt_nxt;
    word_r     <= word_nxt;
    rem_r      <= rem_nxt;
    res_row_r  <= res_row_nxt;
    res_vert_r <= res_vert_nxt;
    res_hor_r  <= res_hor_nxt;
    res_last_r <= res_last_nxt;
  end

  assign row_index        = res_row_r[out_slot];
  assign vertical_walls   = res_vert_r[out_slot];
  assign horizontal_walls = res_hor_r[out_slot];
  assign final_row        = res_last_r[out_slot];

endmodule

// ===== hw/rtl/emrg_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emrg_ctrl
// Controller: steps the row phases, tracks the use of the current word and
// sequences result delivery.
// ----------------------------------------------------------------------------
module emrg_ctrl
  import emrg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output logic     out_slot,
  output logic     out_end_of_run,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  phase_t     phase_r, phase_nxt;
  mode_t      mode_r, mode_nxt;
  logic       used_r, used_nxt;
  logic [1:0] n_r, n_nxt;

  // Next state.
  always_comb begin
    logic emit;
    logic blocked;
    emit      = 1'b0;
    blocked   = 1'b0;
    phase_nxt = phase_r;
    mode_nxt  = mode_r;
    used_nxt  = used_r;
    n_nxt     = n_r;
    unique case (mode_r)
      MD_IDLE: begin
        if (in_valid) begin
          mode_nxt = MD_RUN;
          used_nxt = 1'b0;
          n_nxt    = 2'd0;
        end
      end
      MD_RUN: begin
        unique case (phase_r)
          PH_START: phase_nxt = PH_ROW;
          PH_ROW: begin
            if (!stat.walk_lt_w) phase_nxt = PH_VWALK;
          end
          PH_VWALK: begin
            if (stat.pair_end) begin
              if (stat.last_row) begin
                emit      = 1'b1;
                phase_nxt = PH_START;
              end else begin
                phase_nxt = PH_SETFIRST;
              end
            end else if (!stat.pair_same) begin
              if (used_r) blocked = 1'b1;
              else used_nxt = 1'b1;
            end
          end
          PH_SETFIRST, PH_SETNEXT: begin
            if (!stat.walk_lt_w) begin
              if (stat.found) begin
                phase_nxt = PH_FAILSAFE;
              end else begin
                emit      = 1'b1;
                phase_nxt = PH_ROW;
              end
            end
          end
          PH_FAILSAFE: begin
            if (used_r) begin
              blocked = 1'b1;
            end else begin
              used_nxt = 1'b1;
              mode_nxt = MD_DIV;
            end
          end
          PH_MEMBER: begin
            if (!stat.walk_lt_w) begin
              phase_nxt = PH_SETNEXT;
            end else if (stat.at_cur) begin
              if (used_r) blocked = 1'b1;
              else used_nxt = 1'b1;
            end
          end
          default: phase_nxt = PH_START;
        endcase
        if (emit) begin
          n_nxt = n_r + 2'd1;
          if (n_r == 2'd1) mode_nxt = MD_OUT0;
        end
        if (blocked) begin
          mode_nxt = (n_r == 2'd0) ? MD_IDLE : MD_OUT0;
        end
      end
      MD_DIV: begin
        if (stat.div_last) begin
          mode_nxt  = MD_RUN;
          phase_nxt = PH_MEMBER;
        end
      end
      MD_OUT0: begin
        if (out_ready) mode_nxt = (n_r == 2'd2) ? MD_OUT1 : MD_IDLE;
      end
      MD_OUT1: begin
        if (out_ready) mode_nxt = MD_IDLE;
      end
      default: mode_nxt = MD_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    in_ready       = mode_r == MD_IDLE;
    out_valid      = (mode_r == MD_OUT0) || (mode_r == MD_OUT1);
    out_slot       = mode_r == MD_OUT1;
    out_end_of_run = (mode_r == MD_OUT1) || (mode_r == MD_OUT0 && n_r == 2'd1);
    cmd.op         = OP_NONE;
    cmd.load       = in_valid && (mode_r == MD_IDLE);
    cmd.slot       = n_r[0];
    cmd.first      = phase_r == PH_SETFIRST;
    cmd.last       = 1'b0;
    if (mode_r == MD_DIV) begin
      cmd.op = OP_DIV_STEP;
    end else if (mode_r == MD_RUN) begin
      unique case (phase_r)
        PH_START: cmd.op = OP_START;
        PH_ROW:   cmd.op = stat.walk_lt_w ? OP_FILL : OP_ROW_INIT;
        PH_VWALK: begin
          if (stat.pair_end) begin
            if (stat.last_row) begin
              cmd.op   = OP_EMIT;
              cmd.last = 1'b1;
            end else begin
              cmd.op = OP_PICK_CLR;
            end
          end else if (stat.pair_same) begin
            cmd.op = OP_VW_SAME;
          end else if (!used_r) begin
            cmd.op = OP_VW_DRAW;
          end
        end
        PH_SETFIRST, PH_SETNEXT: begin
          if (stat.walk_lt_w) cmd.op = OP_PICK_COL;
          else cmd.op = stat.found ? OP_PICK_TAKE : OP_EMIT;
        end
        PH_FAILSAFE: begin
          if (!used_r) cmd.op = OP_DIV_INIT;
        end
        PH_MEMBER: begin
          if (!stat.walk_lt_w) cmd.op = OP_MEMBER_END;
          else if (!stat.at_cur) cmd.op = OP_SKIP;
          else if (!used_r) cmd.op = OP_MEMBER_DRAW;
        end
        default: cmd.op = OP_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      mode_r  <= MD_IDLE;
      used_r  <= 1'b0;
      n_r     <= 2'd0;
    end else begin
      phase_r <= phase_nxt;
      mode_r  <= mode_nxt;
      used_r  <= used_nxt;
      n_r     <= n_nxt;
    end
  end

  // A second word is only shown when two rows were finished.
  a_out1_two : assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MD_OUT1 |-> n_r == 2'd2) else $error("second word without two rows");

  // Delivery never starts with an empty buffer.
  a_out0_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MD_OUT0 |-> n_r != 2'd0) else $error("delivery with no rows");

  // An accepted word starts processing right away.
  a_accept_run : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> mode_r == MD_RUN && !used_r) else $error("word not started");

  // The remainder unit only runs for a fail-safe pick, after using the word.
  a_div_phase : assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MD_DIV |-> phase_r == PH_FAILSAFE && used_r) else $error("stray divide");

endmodule

// ===== hw/rtl/eller_maze_row_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eller_maze_row_generator
// Eller's-algorithm maze builder: consumes random words, emits finished rows.
// ----------------------------------------------------------------------------
// Each accepted word is used at the next random draw point of the row in
// progress; the block then keeps working until it needs another word, and
// delivers the zero, one or two rows finished meanwhile, the last flagged by
// end_of_run. Work is one column per cycle while the block neither waits for
// a word nor delivers rows: label fill and each set search walk cols_in_use
// columns, a merge or wall step handles one column pair, and a fail-safe
// pick runs in the bit-serial remainder unit. No clearing pass follows reset.
// Registers are to be written by the user only while the block is idle; the
// block itself does not enforce this.
module eller_maze_row_generator
  import emrg_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [WORD_W-1:0]    in_random_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ROW_W-1:0]     out_row_index,
  output logic [COLUMNS:0]     out_vertical_walls,
  output logic [COLUMNS-1:0]   out_horizontal_walls,
  output logic                 out_final_row,
  output logic                 out_end_of_run,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  logic [ROW_W-1:0]  row_count_r;
  logic [CIU_W-1:0]  cols_r;
  logic [WORD_W-1:0] thresh_r;
  logic [1:0]        reg_idx;
  logic              wr_en;
  logic              out_slot;
  dp_cmd_t           cmd;
  dp_stat_t          stat;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= ROW_COUNT_RST;
      cols_r      <= COLS_RST;
      thresh_r    <= THRESH_RST;
    end else if (wr_en) begin
      if (reg_idx == REG_ROW_COUNT)      row_count_r <= pwdata[ROW_W-1:0];
      if (reg_idx == REG_COLS_IN_USE)    cols_r      <= pwdata[CIU_W-1:0];
      if (reg_idx == REG_OPEN_THRESHOLD) thresh_r    <= pwdata[WORD_W-1:0];
    end
  end

  // Read back.
  always_comb begin
    priority case (reg_idx)
      REG_ROW_COUNT:      prdata = {{(PDATA_W-ROW_W){1'b0}}, row_count_r};
      REG_COLS_IN_USE:    prdata = {{(PDATA_W-CIU_W){1'b0}}, cols_r};
      REG_OPEN_THRESHOLD: prdata = {{(PDATA_W-WORD_W){1'b0}}, thresh_r};
      default:            prdata = '0;
    endcase
  end

  emrg_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_slot       (out_slot),
    .out_end_of_run (out_end_of_run),
    .cmd            (cmd),
    .stat           (stat)
  );

  emrg_dp #(
    .COLUMNS (COLUMNS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_word          (in_random_word),
    .row_count        (row_count_r),
    .cols_in_use      (cols_r),
    .open_threshold   (thresh_r),
    .out_slot         (out_slot),
    .row_index        (out_row_index),
    .vertical_walls   (out_vertical_walls),
    .horizontal_walls (out_horizontal_walls),
    .final_row        (out_final_row)
  );

endmodule
